// File: sv/lphs_pkg.sv
// Package: types, constants and hash for the hash set pool.
`default_nettype none
package lphs_pkg;
    localparam int SLOTS   = 256;
    localparam int SETS    = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int SET_W   = $clog2(SETS);
    localparam int ADDR_W  = SLOT_W + SET_W;
    localparam int CNT_W   = 9;
    localparam logic [31:0] HASH_MUL = 32'd2654435761;

    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_DESTROY  = 3'd1,
        CMD_INSERT   = 3'd2,
        CMD_CONTAINS = 3'd3,
        CMD_REMOVE   = 3'd4,
        CMD_CLEAR    = 3'd5,
        CMD_SIZE     = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

    // one slot entry as stored in memory
    typedef struct packed {
        logic [1:0]  mark;
        logic [31:0] key;
    } t_slot;
endpackage
`default_nettype wire

// File: sv/linear_probe_int_hash_set_pool_unit.sv
// Top level of the integer hash set pool.
// One command per transaction: start is taken while busy is low and exactly one
// result strobe follows; the receiver cannot stall. Busy is also high during reset.
// Destroy, size, a create with no free handle and the invalid-handle cases go from
// decode straight to the done state. Contains/insert/remove hash the key, then probe
// slots in turn (one memory read then compare per slot). Clear and a successful create
// sweep all 256 slots of the set through the single slot memory port. After reset the
// whole slot memory (16384 entries) is swept empty before the first command is taken.
`default_nettype none
module linear_probe_int_hash_set_pool_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [5:0]  i_set_handle,
    input  wire logic [31:0] i_key,
    output logic             o_valid,
    output logic [5:0]       o_new_handle,
    output logic             o_found,
    output logic [8:0]       o_count,
    output logic             o_empty_res
);
    localparam int SW = lphs_pkg::SLOT_W;
    localparam int HW = lphs_pkg::SET_W;
    localparam int AW = lphs_pkg::ADDR_W;
    localparam int CW = lphs_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_HASH, S_READ, S_CHECK, S_WIPE, S_DONE
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_init_addr;
    logic [2:0]        r_cmd;
    logic [HW-1:0]     r_h;
    logic [31:0]       r_key;
    logic [31:0]       r_prod;
    logic [SW-1:0]     r_pos;
    logic [SW:0]       r_probes;
    logic              r_alive [lphs_pkg::SETS];
    logic [5:0]        r_new_handle;
    logic              r_found;
    logic [CW-1:0]     r_out_count;
    logic              r_empty;
    logic              r_valid;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    lphs_pkg::t_slot   mem_wdata;
    lphs_pkg::t_slot   mem_rdata;

    // per-set occupied count; only read for live sets, which create has zeroed
    logic [CW-1:0]     cnt_mem [lphs_pkg::SETS];
    logic [CW-1:0]     r_cnt_rd;
    logic              cnt_we;
    logic [HW-1:0]     cnt_waddr;
    logic [CW-1:0]     cnt_wdata;
    logic [HW-1:0]     cnt_raddr;

    lphs_slot_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    // lowest dead handle from 1 upward
    logic [HW-1:0] free_h;
    logic          free_ok;
    always_comb begin
        free_h  = '0;
        free_ok = 1'b0;
        for (int i = lphs_pkg::SETS - 1; i >= 1; i--) begin
            if (!r_alive[i] && i < 64) begin
                free_h  = HW'(i);
                free_ok = 1'b1;
            end
        end
    end

    logic h_ok;
    assign h_ok = (r_h != '0) && r_alive[r_h];

    // count read lands in the decode cycle for the accepted handle
    assign cnt_raddr = (r_state == S_IDLE) ? HW'(i_set_handle) : r_h;

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rd <= cnt_mem[cnt_raddr];
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_h;
        cnt_wdata = '0;
        case (r_state)
            S_DECODE: begin
                if (r_cmd == lphs_pkg::CMD_CREATE && free_ok) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = free_h;
                end else if (r_cmd == lphs_pkg::CMD_CLEAR && h_ok) begin
                    cnt_we = 1'b1;
                end
            end
            S_CHECK: begin
                if (r_cmd == lphs_pkg::CMD_INSERT) begin
                    if (mem_rdata.mark != lphs_pkg::MARK_USED && r_cnt_rd != '1) begin
                        cnt_we    = 1'b1;
                        cnt_wdata = r_cnt_rd + 1'b1;
                    end
                end else if (r_cmd == lphs_pkg::CMD_REMOVE &&
                             mem_rdata.mark == lphs_pkg::MARK_USED &&
                             mem_rdata.key == r_key && r_cnt_rd != '0) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = r_cnt_rd - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = {r_h, r_pos};
        mem_wdata = '{mark: lphs_pkg::MARK_EMPTY, key: r_key};
        case (r_state)
            S_INIT: begin
                mem_we   = 1'b1;
                mem_addr = r_init_addr;
            end
            S_WIPE: begin
                mem_we = 1'b1;
            end
            S_CHECK: begin
                if (r_cmd == lphs_pkg::CMD_INSERT &&
                    mem_rdata.mark != lphs_pkg::MARK_USED) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{mark: lphs_pkg::MARK_USED, key: r_key};
                end else if (r_cmd == lphs_pkg::CMD_REMOVE &&
                             mem_rdata.mark == lphs_pkg::MARK_USED &&
                             mem_rdata.key == r_key) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{mark: lphs_pkg::MARK_DELETED, key: mem_rdata.key};
                end
            end
            default: ;
        endcase
    end

    assign busy         = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid      = r_valid && i_rst_n;
    assign o_new_handle = r_new_handle;
    assign o_found      = r_found;
    assign o_count      = r_out_count;
    assign o_empty_res  = r_empty;

    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            for (int i = 0; i < lphs_pkg::SETS; i++) begin
                r_alive[i] <= 1'b0;
            end
        end else begin
            case (r_state)
                S_INIT: begin
                    r_init_addr <= r_init_addr + 1'b1;
                    if (&r_init_addr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_command;
                        r_h     <= HW'(i_set_handle);
                        r_key   <= i_key;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_new_handle <= '0;
                    r_found      <= 1'b0;
                    r_out_count  <= '0;
                    r_empty      <= 1'b0;
                    r_pos        <= '0;
                    r_probes     <= '0;
                    r_state      <= S_DONE;
                    case (r_cmd)
                        lphs_pkg::CMD_CREATE: begin
                            if (free_ok) begin
                                r_h          <= free_h;
                                r_alive[free_h] <= 1'b1;
                                r_new_handle <= 6'(free_h);
                                r_state      <= S_WIPE;
                            end
                        end
                        lphs_pkg::CMD_DESTROY: begin
                            if (r_h != '0) r_alive[r_h] <= 1'b0;
                        end
                        lphs_pkg::CMD_INSERT, lphs_pkg::CMD_CONTAINS,
                        lphs_pkg::CMD_REMOVE: begin
                            if (h_ok) begin
                                r_prod  <= r_key * lphs_pkg::HASH_MUL;
                                r_state <= S_HASH;
                            end
                        end
                        lphs_pkg::CMD_CLEAR: begin
                            if (h_ok) begin
                                r_state      <= S_WIPE;
                            end
                        end
                        lphs_pkg::CMD_SIZE: begin
                            r_out_count <= h_ok ? r_cnt_rd : '0;
                            r_empty     <= h_ok ? (r_cnt_rd == '0) : 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_HASH: begin
                    r_pos   <= r_prod[SW-1:0];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state  <= S_READ;
                    r_pos    <= r_pos + 1'b1;
                    r_probes <= r_probes + 1'b1;
                    if (r_cmd == lphs_pkg::CMD_INSERT) begin
                        if (mem_rdata.mark != lphs_pkg::MARK_USED) begin
                            r_state <= S_DONE;
                        end else if (mem_rdata.key == r_key) begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        if (mem_rdata.mark == lphs_pkg::MARK_EMPTY) begin
                            r_state <= S_DONE;
                        end else if (mem_rdata.mark == lphs_pkg::MARK_USED &&
                                     mem_rdata.key == r_key) begin
                            if (r_cmd == lphs_pkg::CMD_CONTAINS) r_found <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end
                    if (r_probes == (SW+1)'(lphs_pkg::SLOTS - 1)) r_state <= S_DONE;
                end
                S_WIPE: begin
                    r_pos <= r_pos + 1'b1;
                    if (&r_pos) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/lphs_slot_ram.sv
// Single-port slot memory with registered read data.
`default_nettype none
module lphs_slot_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [lphs_pkg::ADDR_W-1:0] i_addr,
    input  wire lphs_pkg::t_slot             i_wdata,
    output lphs_pkg::t_slot                  o_rdata
);
    lphs_pkg::t_slot mem [2**lphs_pkg::ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule
`default_nettype wire

// File: sv/lphs_checker.sv
// Port-level checker for the hash set pool, bound to the top level.
`default_nettype none
module lphs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic [5:0] o_new_handle,
    input wire logic       o_found,
    input wire logic [8:0] o_count,
    input wire logic       o_empty_res
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe longer than one cycle");
    a_strobe_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("strobe while busy");
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_empty_res) |-> (o_count == '0 && !o_found && o_new_handle == '0))
        else $error("empty result with nonzero fields");
endmodule

bind linear_probe_int_hash_set_pool_unit lphs_checker u_lphs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_new_handle(o_new_handle), .o_found(o_found),
    .o_count(o_count), .o_empty_res(o_empty_res)
);
`default_nettype wire
